// File: src/bpq_pkg.sv
// Package for the bounded priority queue: item structs, mode and status codes,
// controller states and parameter defaults. No dependencies.
package bpq_pkg;

    // Parameter defaults
    localparam int DEF_CAPACITY       = 128;
    localparam int DEF_DATA_WIDTH     = 32;
    localparam int DEF_PRIORITY_WIDTH = 8;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] in_data;
        logic        [7:0]  in_priority;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] out_data;
        logic        [7:0]  out_priority;
        logic        [7:0]  entry_count_now;
        logic signed [31:0] oldest_data;
        logic        [7:0]  oldest_priority;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_DONE
    } t_state;

endpackage

// File: src/bounded_priority_queue_fifo_ties_top.sv
// Bounded priority queue with FIFO order among equal priorities.
// Depends on bpq_pkg and bpq_ram.
//
// Usage: one input channel (i_valid / o_ready, payload i_item) carries an
// operation: insert, extract highest priority, or clear. One output channel
// (o_valid / i_ready, payload o_item) returns exactly one result per item with
// status, extracted entry, count after the operation and the oldest entry.
// Entries live in arrival order in a single-port-read, single-port-write RAM
// with registered read data; the oldest entry is mirrored in a register.
// Insert, clear and the unused mode pass from ST_IDLE straight to ST_DONE,
// where the result waits to be loaded into the output register. An extract
// reads every held entry once to find the maximum, then shifts the entries
// behind the winner up by one, one RAM read and one write per cycle. The
// single RAM read port sets the pace of both passes. One item is in work at
// a time; o_ready is high while the controller is idle, even if a result
// still waits in the output register. If the receiver stalls, the finished
// result of the next item waits in the controller until the output register
// frees up.
// Reset empties the queue (count zero) and drops any pending result; the
// RAM contents are not cleared, and no clearing pass is needed.
module bounded_priority_queue_fifo_ties_top #(
    parameter int CAPACITY       = bpq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH     = bpq_pkg::DEF_DATA_WIDTH,
    parameter int PRIORITY_WIDTH = bpq_pkg::DEF_PRIORITY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bpq_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output bpq_pkg::t_out_item o_item
);

    import bpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = DATA_WIDTH + PRIORITY_WIDTH;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Registers
    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [DATA_WIDTH-1:0]     r_head_data, n_head_data;
    logic [PRIORITY_WIDTH-1:0] r_head_prio, n_head_prio;
    logic [1:0]                r_status, n_status;
    logic [CW-1:0]             r_best_idx, n_best_idx;
    logic [DATA_WIDTH-1:0]     r_best_data, n_best_data;
    logic [PRIORITY_WIDTH-1:0] r_best_prio, n_best_prio;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_rvalid, n_rvalid;
    logic [CW-1:0]             r_ridx, n_ridx;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_item, n_out_item;

    // RAM port signals
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [WW-1:0]             w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [WW-1:0]             w_rdata;
    logic [DATA_WIDTH-1:0]     w_rd_data;
    logic [PRIORITY_WIDTH-1:0] w_rd_prio;

    // Control terms
    logic                      w_accept;
    logic                      w_load;
    logic                      w_scan_last;
    logic                      w_move_done;
    logic                      w_issue;
    logic                      w_take_best;
    logic [CW-1:0]             w_best_idx_upd;
    logic [CW-1:0]             w_count_m1;
    logic [CW-1:0]             w_back_idx;

    // Width adaptation between fixed fields and stored widths
    logic [63:0]               w_in_data64;
    logic [63:0]               w_in_prio64;
    logic [63:0]               w_best_data64;
    logic [63:0]               w_best_prio64;
    logic [63:0]               w_head_data64;
    logic [63:0]               w_head_prio64;
    logic [63:0]               w_count64;

    bpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_data = w_rdata[DATA_WIDTH-1:0];
    assign w_rd_prio = w_rdata[DATA_WIDTH +: PRIORITY_WIDTH];

    assign w_in_data64   = 64'(i_item.in_data);
    assign w_in_prio64   = 64'(i_item.in_priority);
    assign w_best_data64 = 64'(r_best_data);
    assign w_best_prio64 = 64'(r_best_prio);
    assign w_head_data64 = 64'(r_head_data);
    assign w_head_prio64 = 64'(r_head_prio);
    assign w_count64     = 64'(r_count);

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    assign w_count_m1  = r_count - CW'(1);
    assign w_back_idx  = r_ridx - CW'(1);
    assign w_issue     = (r_idx < r_count);
    assign w_take_best = r_rvalid && ((r_ridx == '0) || (w_rd_prio > r_best_prio));
    assign w_best_idx_upd = w_take_best ? r_ridx : r_best_idx;
    assign w_scan_last = r_rvalid && (r_ridx == w_count_m1);
    assign w_move_done = !w_issue;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.mode == MODE_EXTRACT && r_count != '0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if (w_move_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_count     = r_count;
        n_head_data = r_head_data;
        n_head_prio = r_head_prio;
        n_status    = r_status;
        n_best_idx  = r_best_idx;
        n_best_data = r_best_data;
        n_best_prio = r_best_prio;
        n_idx       = r_idx;
        n_rvalid    = 1'b0;
        n_ridx      = r_ridx;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = {w_in_prio64[PRIORITY_WIDTH-1:0], w_in_data64[DATA_WIDTH-1:0]};
        w_raddr     = r_idx[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_status    = STAT_OK;
                    n_best_idx  = '0;
                    n_best_data = '0;
                    n_best_prio = '0;
                    n_idx       = '0;
                    case (i_item.mode)
                        MODE_INSERT: begin
                            if (r_count == CAP_CNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                // Append at the tail
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                if (r_count == '0) begin
                                    n_head_data = w_in_data64[DATA_WIDTH-1:0];
                                    n_head_prio = w_in_prio64[PRIORITY_WIDTH-1:0];
                                end
                            end
                        end
                        MODE_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle, compare returned entries in order
                if (w_issue) begin
                    n_idx    = r_idx + CW'(1);
                    n_rvalid = 1'b1;
                    n_ridx   = r_idx;
                end
                if (w_take_best) begin
                    n_best_idx  = r_ridx;
                    n_best_data = w_rd_data;
                    n_best_prio = w_rd_prio;
                end
                if (w_scan_last) begin
                    n_idx    = w_best_idx_upd + CW'(1);
                    n_rvalid = 1'b0;
                end
            end
            ST_MOVE: begin
                // Shift entries behind the winner up by one place
                if (w_issue) begin
                    n_idx    = r_idx + CW'(1);
                    n_rvalid = 1'b1;
                    n_ridx   = r_idx;
                end
                if (r_rvalid) begin
                    w_we    = 1'b1;
                    w_waddr = w_back_idx[AW-1:0];
                    w_wdata = w_rdata;
                    if (r_ridx == CW'(1)) begin
                        n_head_data = w_rd_data;
                        n_head_prio = w_rd_prio;
                    end
                end
                if (w_move_done) begin
                    n_count = w_count_m1;
                end
            end
            ST_DONE: begin
                n_rvalid = 1'b0;
            end
            default: begin
                n_rvalid = 1'b0;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && !i_ready;
        if (w_load) begin
            n_out_valid                = 1'b1;
            n_out_item.status          = r_status;
            n_out_item.out_data        = w_best_data64[31:0];
            n_out_item.out_priority    = w_best_prio64[7:0];
            n_out_item.entry_count_now = w_count64[7:0];
            if (r_count != '0) begin
                n_out_item.oldest_data     = w_head_data64[31:0];
                n_out_item.oldest_priority = w_head_prio64[7:0];
            end else begin
                n_out_item.oldest_data     = '0;
                n_out_item.oldest_priority = '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_head_data <= n_head_data;
        r_head_prio <= n_head_prio;
        r_status    <= n_status;
        r_best_idx  <= n_best_idx;
        r_best_data <= n_best_data;
        r_best_prio <= n_best_prio;
        r_idx       <= n_idx;
        r_ridx      <= n_ridx;
        r_out_item  <= n_out_item;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("held count exceeds capacity");

    a_move_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE && r_rvalid) |-> (r_ridx != '0 && r_ridx < r_count))
        else $error("compaction write outside held entries");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_scan_last) |-> (w_best_idx_upd < r_count))
        else $error("scan winner outside held entries");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.mode == MODE_INSERT && r_count != CAP_CNT)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not advance count");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && r_state == ST_IDLE))
        else $error("finished item not presented");

endmodule

// File: src/bpq_ram.sv
// Entry store of the priority queue: one write port, one read port with
// registered read data. Uses no package items.
module bpq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
